// ===== hw/rtl/surf_pkg.sv =====
// ----------------------------------------------------------------------------
// surf_pkg: shared types and constants of the surface root normal field
// Beat layouts, the side data carried down the pipeline and the fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package surf_pkg;

  localparam int unsigned NormW  = 32;  // cross product component width
  localparam int unsigned SumW   = 64;  // squared norm width
  localparam int unsigned Root1W = 32;  // length, floor(sqrt(sum))
  localparam int unsigned Root2W = 20;  // root length, floor(sqrt(len << 8))
  localparam int unsigned QuoW   = 33;  // floor(2^32 / root), may reach 2^32
  localparam int unsigned FrontStages = 4;
  localparam logic [31:0] LimitReset = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [15:0] du_x;
    logic signed [15:0] du_y;
    logic signed [15:0] du_z;
    logic signed [15:0] dv_x;
    logic signed [15:0] dv_y;
    logic signed [15:0] dv_z;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] rq_x;
    logic signed [31:0] rq_y;
    logic signed [31:0] rq_z;
    logic signed [31:0] norm_x;
    logic signed [31:0] norm_y;
    logic signed [31:0] norm_z;
    logic        [31:0] root_len;
    logic        [31:0] inv_root_len;
    logic               last_out;
  } out_t;

  // Data that rides along with a point while the root and divide cells work.
  typedef struct packed {
    logic signed [NormW-1:0]  n_x;
    logic signed [NormW-1:0]  n_y;
    logic signed [NormW-1:0]  n_z;
    logic        [Root2W-1:0] root;
    logic                     last;
  } side_t;

endpackage

`default_nettype wire

// ===== hw/rtl/surf_front.sv =====
// ----------------------------------------------------------------------------
// surf_front: cross product and squared norm
// Four stages: partial products, normal, squares, sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module surf_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire surf_pkg::in_t      data_i,
  output logic                    valid_o,
  output logic [surf_pkg::SumW-1:0] sum_o,
  output surf_pkg::side_t         side_o
);

  logic [surf_pkg::FrontStages-1:0] vld_q;

  logic signed [31:0] p_q [0:5];
  logic               last1_q, last2_q, last3_q;
  logic signed [31:0] n_q [0:2];
  logic signed [31:0] n3_q [0:2];
  logic        [63:0] sq_q [0:2];
  logic        [63:0] sum_q;
  surf_pkg::side_t    side_q;

  logic signed [32:0] diff_d [0:2];
  logic        [31:0] mag_d  [0:2];

  always_comb begin
    diff_d[0] = 33'(p_q[0]) - 33'(p_q[1]);
    diff_d[1] = 33'(p_q[2]) - 33'(p_q[3]);
    diff_d[2] = 33'(p_q[4]) - 33'(p_q[5]);
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = n_q[i][31] ? 32'(-n_q[i]) : 32'(n_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[surf_pkg::FrontStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0]  <= data_i.du_y * data_i.dv_z;
      p_q[1]  <= data_i.du_z * data_i.dv_y;
      p_q[2]  <= data_i.du_z * data_i.dv_x;
      p_q[3]  <= data_i.du_x * data_i.dv_z;
      p_q[4]  <= data_i.du_x * data_i.dv_y;
      p_q[5]  <= data_i.du_y * data_i.dv_x;
      last1_q <= data_i.last_in;
      for (int i = 0; i < 3; i++) begin
        n_q[i]  <= diff_d[i][31:0];
        sq_q[i] <= 64'(mag_d[i]) * 64'(mag_d[i]);
        n3_q[i] <= n_q[i];
      end
      last2_q <= last1_q;
      last3_q <= last2_q;
      sum_q   <= sq_q[0] + sq_q[1] + sq_q[2];
      side_q.n_x  <= n3_q[0];
      side_q.n_y  <= n3_q[1];
      side_q.n_z  <= n3_q[2];
      side_q.root <= '0;
      side_q.last <= last3_q;
    end
  end

  assign valid_o = vld_q[surf_pkg::FrontStages-1];
  assign sum_o   = sum_q;
  assign side_o  = side_q;

endmodule

`default_nettype wire

// ===== hw/rtl/surf_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// surf_sqrt_cell: one digit step of a restoring square root
// Takes two radicand bits and settles one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module surf_sqrt_cell #(
  parameter int unsigned RW = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire logic [2*RW-1:0]   x_i,
  input  wire logic [RW+1:0]     rem_i,
  input  wire logic [RW-1:0]     root_i,
  input  wire surf_pkg::side_t   side_i,
  output logic                   valid_o,
  output logic [2*RW-1:0]        x_o,
  output logic [RW+1:0]          rem_o,
  output logic [RW-1:0]          root_o,
  output surf_pkg::side_t        side_o
);

  logic [RW+1:0] shifted, trial;
  logic          ge;

  assign shifted = {rem_i[RW-1:0], x_i[2*RW-1 -: 2]};
  assign trial   = {root_i, 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= {x_i[2*RW-3:0], 2'b00};
      rem_o  <= ge ? shifted - trial : shifted;
      root_o <= {root_i[RW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/surf_div_cell.sv =====
// ----------------------------------------------------------------------------
// surf_div_cell: one step of a restoring divide of 2^32 by the root length
// Brings down one dividend bit and settles one quotient bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module surf_div_cell #(
  parameter logic DivBit = 1'b0
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire logic [surf_pkg::Root2W-1:0]  rem_i,
  input  wire logic [surf_pkg::QuoW-1:0]    quo_i,
  input  wire surf_pkg::side_t              side_i,
  output logic                              valid_o,
  output logic [surf_pkg::Root2W-1:0]       rem_o,
  output logic [surf_pkg::QuoW-1:0]         quo_o,
  output surf_pkg::side_t                   side_o
);

  logic [surf_pkg::Root2W:0] shifted, diff;
  logic                      ge;

  assign shifted = {rem_i, DivBit};
  assign ge      = shifted >= {1'b0, side_i.root};
  assign diff    = shifted - {1'b0, side_i.root};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // A zero divisor fills the quotient with ones; the back end discards it.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= ge ? diff[surf_pkg::Root2W-1:0] : shifted[surf_pkg::Root2W-1:0];
      quo_o  <= {quo_i[surf_pkg::QuoW-2:0], ge};
      side_o <= side_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/surf_back.sv =====
// ----------------------------------------------------------------------------
// surf_back: limit check, scaling of the normal and the output register
// Three stages: reciprocal select, magnitude products, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module surf_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire logic [surf_pkg::QuoW-1:0]  quo_i,
  input  wire surf_pkg::side_t            side_i,
  input  wire logic [31:0]                limit_i,
  output logic                            valid_o,
  output surf_pkg::out_t                  data_o
);

  logic [1:0]       vld_q;
  logic             out_vld_q;
  logic [31:0]      inv_q, inv2_q;
  surf_pkg::side_t  side1_q, side2_q;
  logic [63:0]      prod_q [0:2];
  surf_pkg::out_t   out_q;

  logic signed [31:0] n1 [0:2];
  logic signed [31:0] n2 [0:2];
  logic [31:0]        mag  [0:2];
  logic [47:0]        q    [0:2];
  logic [31:0]        rq   [0:2];
  logic [63:0]        rsum;

  always_comb begin
    n1[0] = side1_q.n_x;
    n1[1] = side1_q.n_y;
    n1[2] = side1_q.n_z;
    n2[0] = side2_q.n_x;
    n2[1] = side2_q.n_y;
    n2[2] = side2_q.n_z;
    rsum  = '0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = n1[i][31] ? 32'(-n1[i]) : 32'(n1[i]);
      rsum   = prod_q[i] + 64'h8000;
      q[i]   = rsum[63:16];
      if (n2[i][31]) begin
        rq[i] = (q[i] > 48'h8000_0000) ? 32'h8000_0000 : 32'(-q[i]);
      end else begin
        rq[i] = (q[i] > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[i][31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[0], valid_i};
      out_vld_q <= vld_q[1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // A zero root or a quotient over the limit (2^32 always is) gives zero.
      if (side_i.root == '0 || quo_i > {1'b0, limit_i}) begin
        inv_q <= '0;
      end else begin
        inv_q <= quo_i[31:0];
      end
      side1_q <= side_i;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= 64'(mag[i]) * 64'(inv_q);
      end
      inv2_q  <= inv_q;
      side2_q <= side1_q;
      out_q.rq_x         <= rq[0];
      out_q.rq_y         <= rq[1];
      out_q.rq_z         <= rq[2];
      out_q.norm_x       <= side2_q.n_x;
      out_q.norm_y       <= side2_q.n_y;
      out_q.norm_z       <= side2_q.n_z;
      out_q.root_len     <= 32'(side2_q.root);
      out_q.inv_root_len <= inv2_q;
      out_q.last_out     <= side2_q.last;
    end
  end

  assign valid_o = out_vld_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/surface_root_normal_field.sv =====
// ----------------------------------------------------------------------------
// surface_root_normal_field: normal, root length and scaled normal per point
// Each input beat carries two tangent vectors of one surface point; each
// output beat carries the normal, its root length, the reciprocal and the
// scaled normal for that point, in input order, one output beat per input.
// The input and output channels use valid and stall. The block takes one
// beat per cycle while the pipeline is not held. A point passes the front
// end for the cross product and squared norm, 32 cells for the length
// root, 20 cells for the second root, 33 cells for the reciprocal divide
// and the back end for scaling and the output register. The divide chain,
// one quotient bit per cell, is the longest cell chain.
// When the output register holds a beat and the receiver stalls, the whole
// pipeline holds and the input is stalled; while the output register is
// empty, beats keep flowing in. The limit register is written through its
// own channel, always ready, and should only change while the block is idle.
// Reset empties the pipeline and sets the limit to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module surface_root_normal_field (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire surf_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output surf_pkg::out_t      out_data_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [31:0]    cfg_data_i
);

  localparam int unsigned R1 = surf_pkg::Root1W;
  localparam int unsigned R2 = surf_pkg::Root2W;
  localparam int unsigned QW = surf_pkg::QuoW;

  logic        en;
  logic [31:0] limit_q;

  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= surf_pkg::LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Front end
  logic                     f_valid;
  logic [surf_pkg::SumW-1:0] f_sum;
  surf_pkg::side_t          f_side;

  surf_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i && en),
    .data_i  (in_data_i),
    .valid_o (f_valid),
    .sum_o   (f_sum),
    .side_o  (f_side)
  );

  // Length: floor(sqrt(sum))
  logic              a_vld  [0:R1];
  logic [2*R1-1:0]   a_x    [0:R1];
  logic [R1+1:0]     a_rem  [0:R1];
  logic [R1-1:0]     a_root [0:R1];
  surf_pkg::side_t   a_side [0:R1];

  assign a_vld[0]  = f_valid;
  assign a_x[0]    = f_sum;
  assign a_rem[0]  = '0;
  assign a_root[0] = '0;
  assign a_side[0] = f_side;

  for (genvar g = 0; g < R1; g++) begin : g_len
    surf_sqrt_cell #(.RW(R1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (a_vld[g]),
      .x_i     (a_x[g]),
      .rem_i   (a_rem[g]),
      .root_i  (a_root[g]),
      .side_i  (a_side[g]),
      .valid_o (a_vld[g+1]),
      .x_o     (a_x[g+1]),
      .rem_o   (a_rem[g+1]),
      .root_o  (a_root[g+1]),
      .side_o  (a_side[g+1])
    );
  end

  // Root length: floor(sqrt(length << 8))
  logic              b_vld  [0:R2];
  logic [2*R2-1:0]   b_x    [0:R2];
  logic [R2+1:0]     b_rem  [0:R2];
  logic [R2-1:0]     b_root [0:R2];
  surf_pkg::side_t   b_side [0:R2];

  assign b_vld[0]  = a_vld[R1];
  assign b_x[0]    = {a_root[R1], 8'h00};
  assign b_rem[0]  = '0;
  assign b_root[0] = '0;
  assign b_side[0] = a_side[R1];

  for (genvar g = 0; g < R2; g++) begin : g_root
    surf_sqrt_cell #(.RW(R2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (b_vld[g]),
      .x_i     (b_x[g]),
      .rem_i   (b_rem[g]),
      .root_i  (b_root[g]),
      .side_i  (b_side[g]),
      .valid_o (b_vld[g+1]),
      .x_o     (b_x[g+1]),
      .rem_o   (b_rem[g+1]),
      .root_o  (b_root[g+1]),
      .side_o  (b_side[g+1])
    );
  end

  // Reciprocal: floor(2^32 / root), dividend bits msb first
  logic              c_vld  [0:QW];
  logic [R2-1:0]     c_rem  [0:QW];
  logic [QW-1:0]     c_quo  [0:QW];
  surf_pkg::side_t   c_side [0:QW];

  always_comb begin
    c_side[0]      = b_side[R2];
    c_side[0].root = b_root[R2];
  end
  assign c_vld[0] = b_vld[R2];
  assign c_rem[0] = '0;
  assign c_quo[0] = '0;

  for (genvar g = 0; g < QW; g++) begin : g_div
    surf_div_cell #(.DivBit(g == 0)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c_vld[g]),
      .rem_i   (c_rem[g]),
      .quo_i   (c_quo[g]),
      .side_i  (c_side[g]),
      .valid_o (c_vld[g+1]),
      .rem_o   (c_rem[g+1]),
      .quo_o   (c_quo[g+1]),
      .side_o  (c_side[g+1])
    );
  end

  surf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_vld[QW]),
    .quo_i   (c_quo[QW]),
    .side_i  (c_side[QW]),
    .limit_i (limit_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

`default_nettype wire
